// File: hdl/lzsd_pkg.sv
`default_nettype none
package lzsd_pkg;

	localparam int HIST_DEPTH = 4096;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 16;
	localparam int DIST_W     = 12;
	localparam int LEN_W      = 5;
	localparam int STATUS_W   = 2;
	localparam int HDR_W      = 3;
	localparam int FBI_W      = 4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT_HDR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_DIST  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TRUNC     = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic consume;    // input item accepted
		logic rd;         // issue history read for the next copy byte
		logic emit_copy;  // copy byte ready: write history, load result
		logic emit_end;   // load end result and clear stream state
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_lit;     // current input is a literal
		logic is_match;   // current input completes a valid token
		logic more;       // another copy byte follows the current one
		logic last_q;     // accepted item carried the stream end
	} stat_t;

endpackage
`default_nettype wire

// File: hdl/lzss_stream_decompressor.sv
// results: a literal result is registered and valid in the cycle after its item is accepted; a match
//   reads each byte from history in S_RD and emits it from S_WR, which waits while the output is stalled
// input: one item per cycle for header, flag and literal items while the output is free; a match
//   holds the input until its last byte is emitted, set by the registered read of the single history ram
// reset: arst_n clears the controller, parse state and output valid; history is not cleared
`default_nettype none
module lzss_stream_decompressor
	import lzsd_pkg::*;
#(
	parameter int HISTORY_DEPTH = HIST_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// compressed stream in
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // is_last
	// decompressed results out
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [7:0] out_byte, [9:8] status, [25:10] total_bytes
	output      logic        m_tuser,   // kind: 0 data byte, 1 end of stream
	output      logic        m_tlast    // run_last
);

	cmd_t                cmd;
	stat_t               st;
	logic [BYTE_W-1:0]   out_byte;
	logic [STATUS_W-1:0] out_status;
	logic [COUNT_W-1:0]  out_total;

	// sequencing: accept, copy read/write loop, end result
	lzsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// header, flag and token parsing, history ram and result register
	lzsd_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_byte     (s_tdata),
		.in_last     (s_tlast),
		.out_kind    (m_tuser),
		.out_byte    (out_byte),
		.out_status  (out_status),
		.out_total   (out_total),
		.out_run_last(m_tlast)
	);

	// pack result fields, upper six bits zero-filled to a 32-bit word
	assign m_tdata = {6'b000000, out_total, out_status, out_byte};

endmodule
`default_nettype wire

// File: hdl/lzsd_ram.sv
`default_nettype none
module lzsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/lzsd_dp.sv
`default_nettype none
module lzsd_dp
	import lzsd_pkg::*;
#(
	parameter int HISTORY_DEPTH = HIST_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output      stat_t               st,
	input  wire logic [BYTE_W-1:0]   in_byte,
	input  wire logic                in_last,
	output      logic                out_kind,
	output      logic [BYTE_W-1:0]   out_byte,
	output      logic [STATUS_W-1:0] out_status,
	output      logic [COUNT_W-1:0]  out_total,
	output      logic                out_run_last
);

	localparam int AW = $clog2(HISTORY_DEPTH);

	logic [COUNT_W-1:0]  wc_q;
	logic [COUNT_W-1:0]  target_q;
	logic [HDR_W-1:0]    hdr_q;
	logic [BYTE_W-1:0]   flag_q;
	logic [FBI_W-1:0]    fbi_q;
	logic [BYTE_W-1:0]   pl_q;
	logic                pv_q;
	logic [STATUS_W-1:0] err_q;
	logic [LEN_W-1:0]    len_q;
	logic [DIST_W-1:0]   dist_q;
	logic                last_q;

	logic                active;
	logic                flag_bit;
	logic [DIST_W-1:0]   dist_in;
	logic [LEN_W-1:0]    len_in;
	logic                dist_bad;
	logic                is_lit;
	logic                is_tok_hi;
	logic                more;
	logic [COUNT_W-1:0]  wc_inc;
	logic                ram_we;
	logic [BYTE_W-1:0]   ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	assign active    = (err_q == ST_OK) && hdr_q[2] && (wc_q < target_q);
	assign flag_bit  = flag_q[fbi_q[2:0]];
	assign dist_in   = {in_byte[3:0], pl_q};
	assign len_in    = {1'b0, in_byte[7:4]} + LEN_W'(2);
	assign dist_bad  = (dist_in == '0) || ({4'b0000, dist_in} > wc_q);
	assign is_lit    = active && !fbi_q[3] && flag_bit;
	assign is_tok_hi = active && !fbi_q[3] && !flag_bit && pv_q;
	assign wc_inc    = wc_q + COUNT_W'(1);
	assign more      = (len_q > LEN_W'(1)) && (wc_inc < target_q);

	assign st.is_lit   = is_lit;
	assign st.is_match = is_tok_hi && !dist_bad;
	assign st.more     = more;
	assign st.last_q   = last_q;

	assign ram_we    = (cmd.consume && is_lit) || cmd.emit_copy;
	assign ram_wdata = cmd.emit_copy ? ram_rdata : in_byte;
	assign ram_raddr = AW'(wc_q - {4'b0000, dist_q});

	lzsd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wc_q[AW-1:0]),
		.wr_data(ram_wdata),
		.rd_en  (cmd.rd),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// stream parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= '0;
			target_q <= '0;
			hdr_q    <= '0;
			flag_q   <= '0;
			fbi_q    <= FBI_W'(8);
			pl_q     <= '0;
			pv_q     <= 1'b0;
			err_q    <= ST_OK;
			len_q    <= '0;
			dist_q   <= '0;
			last_q   <= 1'b0;
		end else if (cmd.emit_end) begin
			wc_q     <= '0;
			target_q <= '0;
			hdr_q    <= '0;
			flag_q   <= '0;
			fbi_q    <= FBI_W'(8);
			pl_q     <= '0;
			pv_q     <= 1'b0;
			err_q    <= ST_OK;
			len_q    <= '0;
			last_q   <= 1'b0;
		end else if (cmd.consume) begin
			last_q <= in_last;
			if (err_q == ST_OK) begin
				if (!hdr_q[2]) begin
					if (hdr_q[1:0] == 2'd0) begin
						target_q <= {8'h00, in_byte};
					end else if (hdr_q[1:0] == 2'd1) begin
						target_q[15:8] <= in_byte;
					end
					hdr_q <= hdr_q + HDR_W'(1);
					if (in_last && hdr_q != HDR_W'(3)) begin
						err_q <= ST_SHORT_HDR;
					end
				end else if (wc_q < target_q) begin
					if (fbi_q[3]) begin
						flag_q <= in_byte;
						fbi_q  <= '0;
					end else if (flag_bit) begin
						wc_q  <= wc_inc;
						fbi_q <= fbi_q + FBI_W'(1);
					end else if (!pv_q) begin
						pl_q <= in_byte;
						pv_q <= 1'b1;
						if (in_last) begin
							err_q <= ST_TRUNC;
						end
					end else begin
						pv_q <= 1'b0;
						if (dist_bad) begin
							err_q <= ST_BAD_DIST;
						end else begin
							len_q  <= len_in;
							dist_q <= dist_in;
							fbi_q  <= fbi_q + FBI_W'(1);
						end
					end
				end
			end
		end else if (cmd.emit_copy) begin
			wc_q  <= wc_inc;
			len_q <= len_q - LEN_W'(1);
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (cmd.emit_end) begin
			out_kind     <= 1'b1;
			out_byte     <= '0;
			out_status   <= err_q;
			out_total    <= wc_q;
			out_run_last <= 1'b1;
		end else if (cmd.emit_copy) begin
			out_kind     <= 1'b0;
			out_byte     <= ram_rdata;
			out_status   <= ST_OK;
			out_total    <= wc_inc;
			out_run_last <= !(more || last_q);
		end else if (cmd.consume && is_lit) begin
			out_kind     <= 1'b0;
			out_byte     <= in_byte;
			out_status   <= ST_OK;
			out_total    <= wc_inc;
			out_run_last <= !in_last;
		end
	end

endmodule
`default_nettype wire

// File: hdl/lzsd_ctrl.sv
`default_nettype none
module lzsd_ctrl
	import lzsd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_last,
	output      logic  in_ready,
	output      logic  out_valid,
	input  wire logic  out_ready,
	input  wire stat_t st,
	output      cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_WR   = 4'b0100,
		S_END  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   fire;
	logic   load;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		load          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					cmd.consume = 1'b1;
					load        = st.is_lit;
					if (st.is_match) begin
						state_d = S_RD;
					end else if (in_last) begin
						state_d = S_END;
					end
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				if (out_free) begin
					cmd.emit_copy = 1'b1;
					load          = 1'b1;
					if (st.more) begin
						state_d = S_RD;
					end else if (st.last_q) begin
						state_d = S_END;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_END: begin
				if (out_free) begin
					cmd.emit_end = 1'b1;
					load         = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/lzsd_chk.sv
`default_nettype none
module lzsd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// end result always closes the run of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
		else $error("end result malformed");

	// data results carry ok status
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[9:8] == 2'd0)
		else $error("data result with nonzero status");

	// data results count from one
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[25:10] != 16'd0)
		else $error("data result with zero count");

endmodule

bind lzss_stream_decompressor lzsd_chk u_lzsd_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
`default_nettype wire

// File: bench/tb_lzss_stream_decompressor.sv
module tb_lzss_stream_decompressor;
	import lzsd_pkg::*;

	localparam int RAND_ITEMS   = 206;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT        = 500000;
	localparam int MAX_PRINTS   = 50;

	// ways a random stream is broken
	localparam int BRK_NONE  = 0;
	localparam int BRK_DIST  = 1;
	localparam int BRK_TRUNC = 2;

	typedef struct packed {
		logic              kind;
		logic [7:0]        data;
		logic [STATUS_W-1:0] status;
		logic [15:0]       total;
		logic              last;
	} out_rec_t;

	typedef struct packed {
		logic [7:0]          data;
		logic                last;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [15:0]         total;
	} dir_row_t;

	localparam int DIR_COUNT = 24;

	// typed rows carry the whole end result; the rest go through the decoder model
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		// header cut after one byte
		'{8'h05, 1'b1, 1'b1, ST_SHORT_HDR, 16'd0},
		// largest target, flag 00, token ffff: distance 4095 with nothing written
		'{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'hFF, 1'b1, 1'b1, ST_BAD_DIST, 16'd0},
		// target zero: the byte after the header is ignored
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h12, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h34, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h5A, 1'b1, 1'b1, ST_OK, 16'd0},
		// target 21: literal, overlapping run of 17, two literals, cut token
		'{8'h15, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h0D, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'hF0, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'h80, 1'b0, 1'b0, ST_OK, 16'd0},
		'{8'hC3, 1'b1, 1'b1, ST_TRUNC, 16'd20}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	lzss_stream_decompressor uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// decoder model state
	logic [7:0]          hist [HIST_DEPTH];
	logic [15:0]         wcount;
	logic [15:0]         target;
	logic [HDR_W-1:0]    hdr_idx;
	logic [7:0]          flag_bits;
	logic [FBI_W-1:0]    flag_pos;
	logic [7:0]          tok_low;
	logic                tok_pending;
	logic [STATUS_W-1:0] err_code;

	out_rec_t   step_out [$];
	out_rec_t   decoded_q [$];
	logic [7:0] frame [$];

	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	bit          hold_req = 1'b0;

	// expectation typed into the directed table for the item on offer
	bit                  row_typed = 1'b0;
	logic [STATUS_W-1:0] row_status = ST_OK;
	logic [15:0]         row_total = 16'd0;

	task automatic clear_stream();
		wcount = 16'd0;
		target = 16'd0;
		hdr_idx = '0;
		flag_bits = 8'h00;
		flag_pos = FBI_W'(8);
		tok_low = 8'h00;
		tok_pending = 1'b0;
		err_code = ST_OK;
	endtask

	task automatic put_byte(input logic [7:0] data);
		out_rec_t rec;
		hist[wcount[11:0]] = data;
		wcount = wcount + 16'd1;
		rec = '{1'b0, data, ST_OK, wcount, 1'b0};
		step_out.push_back(rec);
	endtask

	task automatic decode_item(input logic [7:0] data, input bit last);
		logic [15:0] token;
		logic [15:0] src;
		out_rec_t    rec;
		int unsigned run_len;
		int unsigned distance;
		int unsigned k;
		step_out.delete();
		if (err_code == ST_OK) begin
			if (hdr_idx < 4) begin
				if (hdr_idx == 0)
					target = {8'h00, data};
				else if (hdr_idx == 1)
					target[15:8] = data;
				hdr_idx = hdr_idx + 1'b1;
				if (last && hdr_idx < 4)
					err_code = ST_SHORT_HDR;
			end else if (wcount < target) begin
				if (flag_pos >= 8) begin
					flag_bits = data;
					flag_pos = '0;
				end else if (flag_bits[flag_pos[2:0]]) begin
					put_byte(data);
					flag_pos = flag_pos + 1'b1;
				end else if (!tok_pending) begin
					tok_low = data;
					tok_pending = 1'b1;
					if (last)
						err_code = ST_TRUNC;
				end else begin
					token = {data, tok_low};
					run_len = 32'(token[15:12]) + 2;
					distance = 32'(token[11:0]);
					tok_pending = 1'b0;
					if (distance == 0 || distance > 32'(wcount)) begin
						err_code = ST_BAD_DIST;
					end else begin
						// byte by byte, so an overlapping run repeats fresh output
						for (k = 0; k < run_len && wcount < target; k++) begin
							src = wcount - 16'(distance);
							put_byte(hist[src[11:0]]);
						end
						flag_pos = flag_pos + 1'b1;
					end
				end
			end
		end
		if (last) begin
			rec = '{1'b1, 8'h00, err_code, wcount, 1'b0};
			step_out.push_back(rec);
			clear_stream();
		end
		if (step_out.size() != 0) begin
			rec = step_out[$];
			rec.last = 1'b1;
			step_out[$] = rec;
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at result %0d: %s got %0h want %0h",
			         results_seen, what, got, want);
	endtask

	task automatic check_result();
		out_rec_t want;
		if (decoded_q.size() == 0) begin
			report_mismatch("result with nothing expected", m_tdata, 0);
			return;
		end
		want = decoded_q.pop_front();
		if (m_tuser !== want.kind)
			report_mismatch("kind", m_tuser, want.kind);
		if (m_tdata[7:0] !== want.data)
			report_mismatch("out_byte", m_tdata[7:0], want.data);
		if (m_tdata[9:8] !== want.status)
			report_mismatch("status", m_tdata[9:8], want.status);
		if (m_tdata[25:10] !== want.total)
			report_mismatch("total_bytes", m_tdata[25:10], want.total);
		if (m_tlast !== want.last)
			report_mismatch("run_last", m_tlast, want.last);
	endtask

	task automatic take_item(input logic [7:0] data, input bit last);
		out_rec_t rec;
		decode_item(data, last);
		if (row_typed) begin
			rec = '{1'b1, 8'h00, row_status, row_total, 1'b1};
			decoded_q.push_back(rec);
		end else begin
			foreach (step_out[i])
				decoded_q.push_back(step_out[i]);
		end
	endtask

	// accepted items feed the model, accepted results are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				take_item(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				check_result();
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic set_phase(input int unsigned p);
		case (p)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 70;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 70;
			end
			default: begin
				send_idle_pct = 34;
				recv_stall_pct = 34;
			end
		endcase
	endtask

	// entered and left just after a falling edge
	task automatic send_item(input logic [7:0] data, input bit last, input bit typed,
	                         input logic [STATUS_W-1:0] st, input logic [15:0] tot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= last;
		row_typed = typed;
		row_status = st;
		row_total = tot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// mostly well-formed streams; some noise, short headers, bad tokens and cut streams
	task automatic build_stream();
		int unsigned mode;
		int unsigned tgt;
		int unsigned made;
		int unsigned brk_at;
		int unsigned brk;
		int unsigned k;
		int unsigned lim;
		int unsigned distance;
		int unsigned cut;
		bit          stop;
		logic [3:0]  nib;
		logic [7:0]  flag;
		logic [7:0]  grp [$];
		frame.delete();
		mode = $urandom_range(99);
		if (mode < 8) begin
			repeat ($urandom_range(1, 3))
				frame.push_back(8'($urandom));
			return;
		end
		if (mode < 14) begin
			repeat ($urandom_range(1, 24))
				frame.push_back(8'($urandom));
			return;
		end
		brk = (mode < 22) ? BRK_DIST : (mode < 30) ? BRK_TRUNC : BRK_NONE;
		tgt = ($urandom_range(14) == 0) ? $urandom_range(150, 500) : $urandom_range(1, 64);
		if ($urandom_range(19) == 0)
			tgt = 0;
		brk_at = (tgt == 0) ? 0 : $urandom_range(0, tgt - 1);
		frame.push_back(8'(tgt));
		frame.push_back(8'(tgt >> 8));
		frame.push_back(8'($urandom));
		frame.push_back(8'($urandom));
		made = 0;
		stop = 1'b0;
		while (made < tgt && !stop) begin
			flag = 8'($urandom);
			grp.delete();
			for (k = 0; k < 8 && made < tgt && !stop; k++) begin
				if (brk != BRK_NONE && made >= brk_at) begin
					flag[k] = 1'b0;
					if (brk == BRK_TRUNC) begin
						grp.push_back(8'($urandom));
					end else begin
						// distance zero or reaching past what was written
						distance = $urandom_range(1) ? 0 : $urandom_range(made + 1, 4095);
						nib = 4'($urandom);
						grp.push_back(8'(distance));
						grp.push_back({nib, 4'(distance >> 8)});
					end
					stop = 1'b1;
				end else if (made == 0 || $urandom_range(1)) begin
					flag[k] = 1'b1;
					grp.push_back(8'($urandom));
					made++;
				end else begin
					flag[k] = 1'b0;
					nib = 4'($urandom);
					lim = (made > 4095) ? 4095 : made;
					distance = $urandom_range(1, lim);
					grp.push_back(8'(distance));
					grp.push_back({nib, 4'(distance >> 8)});
					made = made + nib + 2;
					if (made > tgt)
						made = tgt;
				end
			end
			frame.push_back(flag);
			foreach (grp[i])
				frame.push_back(grp[i]);
		end
		// bytes after an error or past the target are discarded by the block
		if (brk == BRK_DIST || (brk == BRK_NONE && $urandom_range(2) == 0)) begin
			repeat ($urandom_range(1, 5))
				frame.push_back(8'($urandom));
		end
		if (mode < 38) begin
			cut = $urandom_range(4, frame.size());
			while (frame.size() > cut)
				void'(frame.pop_back());
		end
	endtask

	initial begin
		int unsigned stream_no;
		int unsigned budget;
		clear_stream();
		set_phase(0);
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (DIR_ROWS[i])
			send_item(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed,
			          DIR_ROWS[i].status, DIR_ROWS[i].total);
		hold_req = 1'b1;
		stream_no = 0;
		while (items_sent < DIR_COUNT + RAND_ITEMS) begin
			set_phase(stream_no % 4);
			build_stream();
			// keep the last stream within the item budget, cut streams are legal
			budget = DIR_COUNT + RAND_ITEMS - items_sent;
			while (frame.size() > 4 && frame.size() > budget)
				void'(frame.pop_back());
			foreach (frame[i])
				send_item(frame[i], i == frame.size() - 1, 1'b0, ST_OK, 16'd0);
			stream_no++;
		end
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
